>>> design/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotate unit
// Holds the fixed-point widths, the rounding constant, the command codes and
// the register indexes used by the rotation pipeline and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    // Quaternion format: signed Q1.15 per component.
    localparam int QUAT_W         = 16;
    localparam int QUAT_FRAC_BITS = 15;
    // Product of two quaternion components.
    localparam int QPROD_W        = 2 * QUAT_W;
    // Rotation matrix entry: a four-term sum, or a doubled two-term sum off the diagonal.
    localparam int MAT_W          = QPROD_W + 2;

    // Coordinate format: signed Q16.16.
    localparam int COORD_W        = 32;
    // Coordinates are split into a signed high half and an unsigned low half.
    localparam int COORD_SPLIT    = 16;
    localparam int PHI_W          = MAT_W + COORD_W - COORD_SPLIT;
    localparam int PLO_W          = MAT_W + COORD_SPLIT + 1;
    localparam int PROD_W         = MAT_W + COORD_W;

    // Matrix entries carry twice the quaternion fraction bits.
    localparam int RND_SHIFT      = 2 * QUAT_FRAC_BITS;
    localparam int RND_W          = PROD_W - RND_SHIFT;
    localparam int ACC_W          = (RND_W + 3 > COORD_W + 2) ? RND_W + 3 : COORD_W + 2;

    // Adding half an output LSB before the shift rounds to nearest, ties up.
    localparam logic signed [PROD_W-1:0] RND_HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (RND_SHIFT - 1);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_ROT_VEC   = 2'd0,
        CMD_ROT_POINT = 2'd1,
        CMD_INV_VEC   = 2'd2,
        CMD_INV_POINT = 2'd3
    } qvr_cmd_t;

    typedef logic signed [QUAT_W-1:0]  quat_comp_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [MAT_W-1:0]   mat_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef mat_t   [2:0][2:0] mat3_t;
    typedef acc_t   [2:0]      acc3_t;
    typedef coord_t [2:0]      coord3_t;

    typedef struct packed {
        quat_comp_t w;
        quat_comp_t x;
        quat_comp_t y;
        quat_comp_t z;
    } qvr_quat_t;

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic    point;
        logic    inverse;
        coord3_t coord;
        coord3_t offset;
    } qvr_item_t;

endpackage

`default_nettype wire

>>> design/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix: rotation matrix stages
// Stage one forms the ten quaternion component products. Stage two sums them
// into the 3x3 rotation matrix and transposes it for the inverse commands.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_matrix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qvr_pkg::qvr_quat_t  quat,
    input  qvr_pkg::qvr_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output qvr_pkg::mat3_t      out_mat,
    output qvr_pkg::qvr_item_t  out_item
);
    import qvr_pkg::*;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic adv1, adv2;

    logic signed [QPROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    qvr_item_t item1_reg, item2_reg;
    mat3_t     mat_reg;
    mat3_t     mat_full;
    mat3_t     mat_sel;

    // A stage moves forward when it is empty or its successor takes its item.
    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        v1_next = adv1 ? in_valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Stage one: quaternion component products.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            ww_reg    <= quat.w * quat.w;
            xx_reg    <= quat.x * quat.x;
            yy_reg    <= quat.y * quat.y;
            zz_reg    <= quat.z * quat.z;
            xy_reg    <= quat.x * quat.y;
            wz_reg    <= quat.w * quat.z;
            xz_reg    <= quat.x * quat.z;
            wy_reg    <= quat.w * quat.y;
            yz_reg    <= quat.y * quat.z;
            wx_reg    <= quat.w * quat.x;
            item1_reg <= in_item;
        end
    end

    // Stage two: matrix entries from the products.
    always_comb begin
        mat_full[0][0] = mat_t'(ww_reg) + mat_t'(xx_reg) - mat_t'(yy_reg) - mat_t'(zz_reg);
        mat_full[1][1] = mat_t'(ww_reg) - mat_t'(xx_reg) + mat_t'(yy_reg) - mat_t'(zz_reg);
        mat_full[2][2] = mat_t'(ww_reg) - mat_t'(xx_reg) - mat_t'(yy_reg) + mat_t'(zz_reg);
        mat_full[0][1] = (mat_t'(xy_reg) - mat_t'(wz_reg)) <<< 1;
        mat_full[1][0] = (mat_t'(xy_reg) + mat_t'(wz_reg)) <<< 1;
        mat_full[0][2] = (mat_t'(xz_reg) + mat_t'(wy_reg)) <<< 1;
        mat_full[2][0] = (mat_t'(xz_reg) - mat_t'(wy_reg)) <<< 1;
        mat_full[1][2] = (mat_t'(yz_reg) - mat_t'(wx_reg)) <<< 1;
        mat_full[2][1] = (mat_t'(yz_reg) + mat_t'(wx_reg)) <<< 1;
    end

    // The inverse rotation uses the transposed matrix.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mat_sel[i][j] = item1_reg.inverse ? mat_full[j][i] : mat_full[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            mat_reg   <= mat_sel;
            item2_reg <= item1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_mat   = mat_reg;
    assign out_item  = item2_reg;

endmodule

`default_nettype wire

>>> design/qvr_mac.sv
// ----------------------------------------------------------------------------
// qvr_mac: matrix times coordinate stages
// Stage three forms split partial products, stage four joins and rounds them,
// stage five sums each row and applies the point offset.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qvr_pkg::mat3_t      in_mat,
    input  qvr_pkg::qvr_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output qvr_pkg::acc3_t      out_acc
);
    import qvr_pkg::*;

    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic v5_reg, v5_next;
    logic adv3, adv4, adv5;

    logic signed [PHI_W-1:0]  pp_hi_reg [3][3];
    logic signed [PLO_W-1:0]  pp_lo_reg [3][3];
    logic signed [PROD_W-1:0] full_prod [3][3];
    logic signed [RND_W-1:0]  rnd_reg   [3][3];
    acc_t                     off_term  [3];
    acc3_t                    acc_next;
    acc3_t                    acc_reg;
    qvr_item_t                item3_reg, item4_reg;

    // Stage advance chain.
    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign in_ready = adv3;

    always_comb begin
        v3_next = adv3 ? in_valid : v3_reg;
        v4_next = adv4 ? v3_reg : v4_reg;
        v5_next = adv5 ? v4_reg : v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // Stage three: each entry times the signed high and unsigned low coordinate halves.
    always_ff @(posedge aclk) begin
        if (adv3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pp_hi_reg[i][j] <= $signed(in_mat[i][j])
                        * $signed(in_item.coord[j][COORD_W-1:COORD_SPLIT]);
                    pp_lo_reg[i][j] <= $signed(in_mat[i][j])
                        * $signed({1'b0, in_item.coord[j][COORD_SPLIT-1:0]});
                end
            end
            item3_reg <= in_item;
        end
    end

    // Stage four: rejoin the halves, add half an LSB and drop the fraction bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                full_prod[i][j] = (PROD_W'(pp_hi_reg[i][j]) <<< COORD_SPLIT)
                                + PROD_W'(pp_lo_reg[i][j]) + RND_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rnd_reg[i][j] <= $signed(full_prod[i][j][PROD_W-1:RND_SHIFT]);
                end
            end
            item4_reg <= item3_reg;
        end
    end

    // Stage five: row sums, plus or minus the offset in the point commands.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!item4_reg.point) begin
                off_term[i] = '0;
            end else if (item4_reg.inverse) begin
                off_term[i] = -ACC_W'($signed(item4_reg.offset[i]));
            end else begin
                off_term[i] = ACC_W'($signed(item4_reg.offset[i]));
            end
            acc_next[i] = ACC_W'(rnd_reg[i][0]) + ACC_W'(rnd_reg[i][1])
                        + ACC_W'(rnd_reg[i][2]) + off_term[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv5) begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_acc   = acc_reg;

endmodule

`default_nettype wire

>>> design/qvr_clamp.sv
// ----------------------------------------------------------------------------
// qvr_clamp: output saturation stage
// Clamps each wide row sum to the 32-bit coordinate range, flags any clamp
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_clamp (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  qvr_pkg::acc3_t   in_acc,
    output logic             out_valid,
    input  logic             out_ready,
    output qvr_pkg::coord3_t out_val,
    output logic             out_sat
);
    import qvr_pkg::*;

    logic    v6_reg, v6_next;
    logic    adv6;
    coord3_t val_next, val_reg;
    logic    sat_next, sat_reg;
    logic    [ACC_W-COORD_W:0] top_bits [3];
    logic    [2:0] ovf;

    assign adv6     = !v6_reg || out_ready;
    assign in_ready = adv6;

    always_comb begin
        v6_next = adv6 ? in_valid : v6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else begin
            v6_reg <= v6_next;
        end
    end

    // A value fits when all bits from the coordinate sign bit upward agree.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            top_bits[i] = in_acc[i][ACC_W-1:COORD_W-1];
            ovf[i]      = !(&top_bits[i]) && (|top_bits[i]);
            if (!ovf[i]) begin
                val_next[i] = in_acc[i][COORD_W-1:0];
            end else if (in_acc[i][ACC_W-1]) begin
                val_next[i] = COORD_MIN;
            end else begin
                val_next[i] = COORD_MAX;
            end
        end
        sat_next = |ovf;
    end

    always_ff @(posedge aclk) begin
        if (adv6) begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_val   = val_reg;
    assign out_sat   = sat_reg;

endmodule

`default_nettype wire

>>> design/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit: top level of the quaternion vector rotator
// Items pass the matrix, MAC and clamp stages in order to the result channel.
// Throughput: one item per cycle unless stalled; six stages with valid bits.
// Stalls back up stage by stage, so a full pipeline holds six items.
// Reset clears all valid bits and loads the identity quaternion (w = 32767).
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port.
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic signed [31:0] s_offset_x,
    input  logic signed [31:0] s_offset_y,
    input  logic signed [31:0] s_offset_z,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic               m_saturated
);
    import qvr_pkg::*;

    qvr_quat_t quat_reg;
    qvr_item_t in_item;

    logic      mat_valid, mat_ready;
    mat3_t     mat_data;
    qvr_item_t mat_item;

    logic      acc_valid, acc_ready;
    acc3_t     acc_data;

    coord3_t   res_val;

    // Orientation quaternion registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg.w <= 16'sd32767;
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUAT_W: quat_reg.w <= cfg_wdata;
                REG_QUAT_X: quat_reg.x <= cfg_wdata;
                REG_QUAT_Y: quat_reg.y <= cfg_wdata;
                REG_QUAT_Z: quat_reg.z <= cfg_wdata;
                default:    quat_reg   <= quat_reg;
            endcase
        end
    end

    // Command decode and input packing.
    always_comb begin
        case (qvr_cmd_t'(s_cmd))
            CMD_ROT_VEC: begin
                in_item.point   = 1'b0;
                in_item.inverse = 1'b0;
            end
            CMD_ROT_POINT: begin
                in_item.point   = 1'b1;
                in_item.inverse = 1'b0;
            end
            CMD_INV_VEC: begin
                in_item.point   = 1'b0;
                in_item.inverse = 1'b1;
            end
            CMD_INV_POINT: begin
                in_item.point   = 1'b1;
                in_item.inverse = 1'b1;
            end
            default: begin
                in_item.point   = 1'b0;
                in_item.inverse = 1'b0;
            end
        endcase
        in_item.coord[0]  = s_coord_x;
        in_item.coord[1]  = s_coord_y;
        in_item.coord[2]  = s_coord_z;
        in_item.offset[0] = s_offset_x;
        in_item.offset[1] = s_offset_y;
        in_item.offset[2] = s_offset_z;
    end

    qvr_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .quat      (quat_reg),
        .in_item   (in_item),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_mat   (mat_data),
        .out_item  (mat_item)
    );

    qvr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_mat    (mat_data),
        .in_item   (mat_item),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_acc   (acc_data)
    );

    qvr_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_acc    (acc_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_val   (res_val),
        .out_sat   (m_saturated)
    );

    assign m_out_x = res_val[0];
    assign m_out_y = res_val[1];
    assign m_out_z = res_val[2];

    // The input side can only stall when a finished result is waiting.
    a_stall_needs_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid
    ) else $error("input stalled while no result is pending");

    // A saturated result must carry a clamped component.
    a_sat_has_clamp: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == COORD_MAX || m_out_x == COORD_MIN ||
             m_out_y == COORD_MAX || m_out_y == COORD_MIN ||
             m_out_z == COORD_MAX || m_out_z == COORD_MIN)
    ) else $error("saturation flagged without a clamped component");

    // Reset empties the pipeline.
    a_reset_empties: assert property (
        @(posedge aclk)
        !aresetn |=> !m_valid
    ) else $error("result valid right after reset");

endmodule

`default_nettype wire
